[sv/aapr_pkg.sv]
// Shared types, widths and the quarter-wave sine table for the axis-angle point rotator.
package aapr_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W = $clog2(SINE_DEPTH + 1);
    localparam int IDX_PROD_W = 15 + IDX_W;

    localparam int PT_W = 24;
    localparam int AX_W = 16;
    localparam int ANG_W = 16;
    localparam int SIN_W = 15;
    localparam int Q_W = 17;
    localparam int SQ_W = 2 * Q_W;
    localparam int TERM_W = 34;
    localparam int MP_W = TERM_W + PT_W;
    localparam int ACC_W = MP_W + 2;
    localparam int FRAC_Q = 14;
    localparam int FRAC_M = 28;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ONE_Q14 = 16384;

    typedef logic [SIN_W-1:0] sine_val_t;
    typedef sine_val_t sine_tab_t [0:SINE_DEPTH];

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } sine_addr_t;

    typedef struct packed {
        logic signed [PT_W-1:0] z;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] x;
    } point_t;

    // Taylor series of the sine up to the fifteenth power, in Q30, rounded to Q1.14.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               minus;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            minus = 1'b1;
            for (int n = 3; n <= 15; n += 2)
            begin
                term = ((term * x2) >> 30) / 64'((n - 1) * n);
                if (minus)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
                minus = !minus;
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 64'sd32768) >>> 16;
            if (sum > ONE_Q14)
            begin
                sum = ONE_Q14;
            end
            tab[k] = sum[SIN_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[sv/aapr_sine_rom.sv]
// Dual-read quarter-wave sine table with registered outputs.
module aapr_sine_rom (
    input  logic                        clk,
    input  logic                        en,
    input  logic [aapr_pkg::IDX_W-1:0]  addr_a,
    input  logic [aapr_pkg::IDX_W-1:0]  addr_b,
    output aapr_pkg::sine_val_t         data_a,
    output aapr_pkg::sine_val_t         data_b
);

    aapr_pkg::sine_val_t data_a_reg;
    aapr_pkg::sine_val_t data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= aapr_pkg::SINE_TAB[addr_a];
            data_b_reg <= aapr_pkg::SINE_TAB[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

[sv/axis_angle_point_rotate.sv]
// Top level: streaming axis-angle point rotation through an eight-stage pipeline.
//
// Each input beat carries a Q15.8 point, a Q1.14 rotation axis and a 16-bit binary
// angle (65536 per turn); each output beat carries the rotated point, rounded and
// saturated to Q15.8. The axis is used as given, with no normalization. The block
// accepts one beat per clock while the output side is ready, and returns each result
// from the output register of the last stage. Stages: half angle and table addresses, sine and
// cosine table read, quaternion scaling, quaternion products, matrix terms, term by
// coordinate products, row sums with rounding, saturation into the output register.
// Every stage holds its beat while the next one is full and stalled, so empty stages
// are filled even under back-pressure. The sine table is a constant ROM and needs no
// initialization time after reset.
module axis_angle_point_rotate (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, point_z, axis_x, axis_y, axis_z, turn_angle
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [71:0]  m_axis_tdata
);

    localparam int NSTAGE = 8;

    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE+1:1] en;

    always_comb
    begin
        en[NSTAGE+1] = m_axis_tready;
        for (int i = NSTAGE; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = valid_reg[NSTAGE];

    function automatic aapr_pkg::sine_addr_t sine_addr(input logic [15:0] a);
        logic [14:0]                       f;
        logic [aapr_pkg::IDX_PROD_W-1:0]   prod;
        aapr_pkg::sine_addr_t              r;
        // Odd quadrants run the quarter wave backwards.
        f = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        prod = aapr_pkg::IDX_PROD_W'(f) * aapr_pkg::IDX_PROD_W'(aapr_pkg::SINE_DEPTH);
        r.idx = prod[14 +: aapr_pkg::IDX_W];
        r.neg = a[15];
        return r;
    endfunction

    // Stage 1: half angle and table addresses.
    aapr_pkg::point_t                  in_pt;
    logic signed [aapr_pkg::AX_W-1:0]  in_ax [3];
    logic signed [aapr_pkg::ANG_W-1:0] in_ang;
    logic signed [aapr_pkg::ANG_W-1:0] half_ang;
    logic [aapr_pkg::ANG_W-1:0]        cos_ang;

    always_comb
    begin
        in_pt.x = s_axis_tdata[23:0];
        in_pt.y = s_axis_tdata[47:24];
        in_pt.z = s_axis_tdata[71:48];
        in_ax[0] = s_axis_tdata[87:72];
        in_ax[1] = s_axis_tdata[103:88];
        in_ax[2] = s_axis_tdata[119:104];
        in_ang = s_axis_tdata[135:120];
        // Halving truncates toward zero, so odd negative angles round up.
        half_ang = (in_ang >>> 1) + $signed({15'd0, in_ang[15] & in_ang[0]});
        cos_ang = 16'(half_ang) + 16'd16384;
    end

    aapr_pkg::sine_addr_t             sin_addr_reg;
    aapr_pkg::sine_addr_t             cos_addr_reg;
    aapr_pkg::point_t                 pt1_reg;
    logic signed [aapr_pkg::AX_W-1:0] ax1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sin_addr_reg <= sine_addr(16'(half_ang));
            cos_addr_reg <= sine_addr(cos_ang);
            pt1_reg <= in_pt;
            ax1_reg <= in_ax;
        end
    end

    // Stage 2: table read.
    aapr_pkg::sine_val_t              sin_mag;
    aapr_pkg::sine_val_t              cos_mag;
    logic                             sin_neg2_reg;
    logic                             cos_neg2_reg;
    aapr_pkg::point_t                 pt2_reg;
    logic signed [aapr_pkg::AX_W-1:0] ax2_reg [3];

    aapr_sine_rom u_sine_rom (
        .clk    (clk),
        .en     (en[2]),
        .addr_a (sin_addr_reg.idx),
        .addr_b (cos_addr_reg.idx),
        .data_a (sin_mag),
        .data_b (cos_mag)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sin_neg2_reg <= sin_addr_reg.neg;
            cos_neg2_reg <= cos_addr_reg.neg;
            pt2_reg <= pt1_reg;
            ax2_reg <= ax1_reg;
        end
    end

    // Stage 3: quaternion. The vector part is the sine scaled by the axis.
    logic signed [15:0]              sin_val;
    logic signed [15:0]              cos_val;
    logic signed [31:0]              sax [3];
    logic signed [31:0]              sax_rnd [3];
    logic signed [aapr_pkg::Q_W-1:0] q3_next [4];

    always_comb
    begin
        sin_val = sin_neg2_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_val = cos_neg2_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        q3_next[0] = aapr_pkg::Q_W'(cos_val);
        for (int i = 0; i < 3; i++)
        begin
            sax[i] = sin_val * ax2_reg[i];
            sax_rnd[i] = sax[i] + 32'sd8192;
            q3_next[i+1] = sax_rnd[i][aapr_pkg::FRAC_Q +: aapr_pkg::Q_W];
        end
    end

    logic signed [aapr_pkg::Q_W-1:0] q3_reg [4];
    aapr_pkg::point_t                pt3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            q3_reg <= q3_next;
            pt3_reg <= pt2_reg;
        end
    end

    // Stage 4: quaternion products. Order: q0q0, q1q1, q2q2, q3q3,
    // q1q2, q0q3, q1q3, q0q2, q2q3, q0q1.
    logic signed [aapr_pkg::SQ_W-1:0] qp4_reg [10];
    aapr_pkg::point_t                 pt4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            qp4_reg[0] <= q3_reg[0] * q3_reg[0];
            qp4_reg[1] <= q3_reg[1] * q3_reg[1];
            qp4_reg[2] <= q3_reg[2] * q3_reg[2];
            qp4_reg[3] <= q3_reg[3] * q3_reg[3];
            qp4_reg[4] <= q3_reg[1] * q3_reg[2];
            qp4_reg[5] <= q3_reg[0] * q3_reg[3];
            qp4_reg[6] <= q3_reg[1] * q3_reg[3];
            qp4_reg[7] <= q3_reg[0] * q3_reg[2];
            qp4_reg[8] <= q3_reg[2] * q3_reg[3];
            qp4_reg[9] <= q3_reg[0] * q3_reg[1];
            pt4_reg <= pt3_reg;
        end
    end

    // Stage 5: rotation matrix terms in Q28, row major.
    logic signed [aapr_pkg::SQ_W+1:0]   qx [10];
    logic signed [aapr_pkg::SQ_W+1:0]   mw [9];
    logic signed [aapr_pkg::TERM_W-1:0] m5_next [9];

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            qx[i] = (aapr_pkg::SQ_W + 2)'(qp4_reg[i]);
        end
        mw[0] = qx[0] + qx[1] - qx[2] - qx[3];
        mw[1] = (qx[4] - qx[5]) <<< 1;
        mw[2] = (qx[6] + qx[7]) <<< 1;
        mw[3] = (qx[4] + qx[5]) <<< 1;
        mw[4] = qx[0] - qx[1] + qx[2] - qx[3];
        mw[5] = (qx[8] - qx[9]) <<< 1;
        mw[6] = (qx[6] - qx[7]) <<< 1;
        mw[7] = (qx[8] + qx[9]) <<< 1;
        mw[8] = qx[0] - qx[1] - qx[2] + qx[3];
        for (int i = 0; i < 9; i++)
        begin
            m5_next[i] = aapr_pkg::TERM_W'(mw[i]);
        end
    end

    logic signed [aapr_pkg::TERM_W-1:0] m5_reg [9];
    aapr_pkg::point_t                   pt5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            m5_reg <= m5_next;
            pt5_reg <= pt4_reg;
        end
    end

    // Stage 6: each term times its coordinate.
    logic signed [aapr_pkg::PT_W-1:0] pcol [3];
    logic signed [aapr_pkg::MP_W-1:0] mp6_reg [9];

    always_comb
    begin
        pcol[0] = pt5_reg.x;
        pcol[1] = pt5_reg.y;
        pcol[2] = pt5_reg.z;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    mp6_reg[3*r+c] <= aapr_pkg::MP_W'(m5_reg[3*r+c]) *
                                      aapr_pkg::MP_W'(pcol[c]);
                end
            end
        end
    end

    // Stage 7: row sums with the rounding half added.
    logic signed [aapr_pkg::ACC_W-1:0] acc7_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc7_reg[r] <= aapr_pkg::ACC_W'(mp6_reg[3*r])
                             + aapr_pkg::ACC_W'(mp6_reg[3*r+1])
                             + aapr_pkg::ACC_W'(mp6_reg[3*r+2])
                             + $signed(aapr_pkg::ACC_W'(1) <<< (aapr_pkg::FRAC_M - 1));
            end
        end
    end

    // Stage 8: scale back to Q15.8 and clip.
    localparam int SH_W = aapr_pkg::ACC_W - aapr_pkg::FRAC_M;

    logic signed [SH_W-1:0]           shifted [3];
    logic signed [aapr_pkg::PT_W-1:0] out_next [3];
    logic signed [aapr_pkg::PT_W-1:0] out_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[r] = acc7_reg[r][aapr_pkg::ACC_W-1:aapr_pkg::FRAC_M];
            if (shifted[r] > $signed(SH_W'(24'h7FFFFF)))
            begin
                out_next[r] = 24'h7FFFFF;
            end
            else if (shifted[r] < -$signed(SH_W'(24'h800000)))
            begin
                out_next[r] = 24'h800000;
            end
            else
            begin
                out_next[r] = shifted[r][aapr_pkg::PT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = {out_reg[2], out_reg[1], out_reg[0]};

endmodule
